@@ hw/rtl/keypoint_slot_selector_assert.svh @@
// assertion macros for the keypoint slot selector checker
// depends on nothing; included by the checker file
`ifndef KEYPOINT_SLOT_SELECTOR_ASSERT_SVH
`define KEYPOINT_SLOT_SELECTOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define KSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypoint slot selector check failed");

// next-cycle implication, disabled while in reset
`define KSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypoint slot selector check failed");

`endif

@@ hw/rtl/kss_pkg.sv @@
// shared constants and types for the keypoint slot selector
// no dependencies; imported by the top level and its checker
`default_nettype none

package kss_pkg;

    // defaults for the top-level parameters
    localparam int ID_BITS_DEFAULT    = 16;
    localparam int COORD_BITS_DEFAULT = 16;

    localparam int NUM_SLOTS = 5;
    localparam int NUM_QUADS = 4;
    localparam int FRAC_BITS = 4;

    // configuration port
    localparam int CFG_BITS      = 12;
    localparam int CFG_ADDR_BITS = 1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

    // item kinds carried on tuser
    localparam logic KIND_OFFER  = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // field widths on the stream ports
    localparam int ID_IN_BITS    = 16;
    localparam int COORD_IN_BITS = 16;
    localparam int ID_OUT_BITS   = 16;

    // input tdata layout
    localparam int IN_ID_LSB     = 0;
    localparam int IN_X_LSB      = IN_ID_LSB + ID_IN_BITS;
    localparam int IN_Y_LSB      = IN_X_LSB + COORD_IN_BITS;
    localparam int IN_PT_BIT     = IN_Y_LSB + COORD_IN_BITS;
    localparam int IN_TDATA_BITS = ((IN_PT_BIT + 1 + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_MASK_LSB   = NUM_SLOTS * ID_OUT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_MASK_LSB + NUM_SLOTS + 7) / 8) * 8;

    // slot numbering, centre first
    typedef logic [2:0] slot_idx_t;
    localparam slot_idx_t SLOT_CENTER      = 3'd0;
    localparam slot_idx_t SLOT_LOWER_RIGHT = 3'd1;

    // quadrant numbering, quadrant slot minus one
    typedef logic [1:0] quad_idx_t;
    localparam quad_idx_t QUAD_LOWER_RIGHT = 2'd0;
    localparam quad_idx_t QUAD_UPPER_RIGHT = 2'd1;
    localparam quad_idx_t QUAD_UPPER_LEFT  = 2'd2;
    localparam quad_idx_t QUAD_LOWER_LEFT  = 2'd3;

endpackage

`default_nettype wire

@@ hw/rtl/keypoint_slot_selector.sv @@
// keypoint slot selector: centre slot and four quadrant slots over a feature stream
// depends on kss_pkg
// pipeline: 3 stages, input register (a), metrics (b) and result register
// throughput: one item per cycle, back to back unless the sink stalls; the centre
//   and quadrant compares against the per-slot metric registers are combinational
// reset: slots empty, image size 640 x 480, all stages empty; no clearing pass
`default_nettype none

module keypoint_slot_selector
    import kss_pkg::*;
#(
    parameter int ID_BITS    = ID_BITS_DEFAULT,
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // configuration writes
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [CFG_BITS-1:0]       cfg_wdata,

    // feature items
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: feature_id, feature_x, feature_y, has_point, zero pad
    input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // tuser: kind
    input  wire logic                      s_axis_tuser,

    // slot results
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // tdata: center_id, lower_right_id, upper_right_id, upper_left_id,
    //        lower_left_id, valid_mask, zero pad
    output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata
);

    // centre coordinate width: (size / 2) << FRAC_BITS
    localparam int CTR_BITS = CFG_BITS - 1 + FRAC_BITS;
    // signed offset from the centre, wide enough for either operand
    localparam int DW = ((COORD_BITS > CTR_BITS) ? COORD_BITS : CTR_BITS) + 1;
    // signed quadrant product
    localparam int PW = 2 * DW;

    // ------------------------------------------------------------------
    // metric helpers
    // ------------------------------------------------------------------
    function automatic logic signed [DW-1:0] offset(input logic [COORD_BITS-1:0] v,
                                                    input logic [CTR_BITS-1:0]   c);
        offset = signed'(DW'(v) - DW'(c));
    endfunction

    function automatic logic [DW-1:0] magnitude(input logic signed [DW-1:0] d);
        magnitude = d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    // chebyshev distance to the centre
    function automatic logic [DW-1:0] cheb_of(input logic [COORD_BITS-1:0] x,
                                              input logic [COORD_BITS-1:0] y,
                                              input logic [CTR_BITS-1:0]   cu,
                                              input logic [CTR_BITS-1:0]   cv);
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        a = magnitude(offset(x, cu));
        b = magnitude(offset(y, cv));
        cheb_of = (a > b) ? a : b;
    endfunction

    // signed product of the offsets
    function automatic logic signed [PW-1:0] prod_of(input logic [COORD_BITS-1:0] x,
                                                     input logic [COORD_BITS-1:0] y,
                                                     input logic [CTR_BITS-1:0]   cu,
                                                     input logic [CTR_BITS-1:0]   cv);
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        dx = offset(x, cu);
        dy = offset(y, cv);
        prod_of = PW'(dx) * PW'(dy);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    logic [CTR_BITS-1:0] cu;
    logic [CTR_BITS-1:0] cv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
            endcase
        end
    end

    // halving truncates, then the fraction bits are appended
    assign cu = {width_reg[CFG_BITS-1:1], {FRAC_BITS{1'b0}}};
    assign cv = {height_reg[CFG_BITS-1:1], {FRAC_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // pipeline handshake: each stage moves when the one after it frees up
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic b_free;
    logic b_adv;
    logic a_adv;
    logic s_accept;

    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign b_free        = !b_valid_reg || out_adv;
    assign b_adv         = b_valid_reg && out_adv;
    assign a_adv         = a_valid_reg && b_free;
    assign s_axis_tready = !a_valid_reg || b_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= s_accept || (a_valid_reg && !b_free);
            b_valid_reg   <= a_adv || (b_valid_reg && !out_adv);
            out_valid_reg <= b_adv || (out_valid_reg && !m_axis_tready);
        end
    end

    // ------------------------------------------------------------------
    // stage a: input register
    // ------------------------------------------------------------------
    logic                  a_kind_reg;
    logic [ID_BITS-1:0]    a_id_reg;
    logic [COORD_BITS-1:0] a_x_reg;
    logic [COORD_BITS-1:0] a_y_reg;
    logic                  a_pt_reg;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_kind_reg <= s_axis_tuser;
            a_id_reg   <= ID_BITS'(s_axis_tdata[IN_ID_LSB +: ID_IN_BITS]);
            a_x_reg    <= COORD_BITS'(s_axis_tdata[IN_X_LSB +: COORD_IN_BITS]);
            a_y_reg    <= COORD_BITS'(s_axis_tdata[IN_Y_LSB +: COORD_IN_BITS]);
            a_pt_reg   <= s_axis_tdata[IN_PT_BIT];
        end
    end

    // ------------------------------------------------------------------
    // stage b: metrics of the incoming feature
    // ------------------------------------------------------------------
    logic signed [DW-1:0] a_dx;
    logic signed [DW-1:0] a_dy;
    quad_idx_t            a_quad;

    assign a_dx = offset(a_x_reg, cu);
    assign a_dy = offset(a_y_reg, cv);

    // right when x >= cu, lower when y >= cv
    always_comb
    begin
        case ({a_dx[DW-1], a_dy[DW-1]})
            2'b00:   a_quad = QUAD_LOWER_RIGHT;
            2'b01:   a_quad = QUAD_UPPER_RIGHT;
            2'b11:   a_quad = QUAD_UPPER_LEFT;
            default: a_quad = QUAD_LOWER_LEFT;
        endcase
    end

    logic                  b_remove_reg;
    logic [ID_BITS-1:0]    b_id_reg;
    logic [COORD_BITS-1:0] b_x_reg;
    logic [COORD_BITS-1:0] b_y_reg;
    quad_idx_t             b_quad_reg;
    logic [DW-1:0]         b_cheb_reg;
    logic signed [PW-1:0]  b_prod_reg;

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            // an offer without a 3-D point behaves as a removal
            b_remove_reg <= (a_kind_reg == KIND_REMOVE) || !a_pt_reg;
            b_id_reg     <= a_id_reg;
            b_x_reg      <= a_x_reg;
            b_y_reg      <= a_y_reg;
            b_quad_reg   <= a_quad;
            b_cheb_reg   <= cheb_of(a_x_reg, a_y_reg, cu, cv);
            b_prod_reg   <= prod_of(a_x_reg, a_y_reg, cu, cv);
        end
    end

    // ------------------------------------------------------------------
    // slot state and update
    // ------------------------------------------------------------------
    logic [NUM_SLOTS-1:0]  valid_reg;
    logic [NUM_SLOTS-1:0]  valid_next;
    logic [ID_BITS-1:0]    slot_id_reg   [NUM_SLOTS];
    logic [ID_BITS-1:0]    slot_id_next  [NUM_SLOTS];
    logic [COORD_BITS-1:0] slot_x_reg    [NUM_SLOTS];
    logic [COORD_BITS-1:0] slot_x_next   [NUM_SLOTS];
    logic [COORD_BITS-1:0] slot_y_reg    [NUM_SLOTS];
    logic [COORD_BITS-1:0] slot_y_next   [NUM_SLOTS];

    // metrics of the held features, kept current against the centre
    logic [DW-1:0]         cheb_reg;
    logic [DW-1:0]         cheb_next;
    logic signed [PW-1:0]  prod_reg      [NUM_QUADS];
    logic signed [PW-1:0]  prod_next     [NUM_QUADS];

    slot_idx_t             b_slot;
    logic                  center_take;
    logic                  quad_take;

    assign b_slot = SLOT_LOWER_RIGHT + slot_idx_t'(b_quad_reg);

    always_comb
    begin
        valid_next   = valid_reg;
        slot_id_next = slot_id_reg;
        slot_x_next  = slot_x_reg;
        slot_y_next  = slot_y_reg;
        center_take  = 1'b0;
        quad_take    = 1'b0;
        if (b_adv)
        begin
            if (b_remove_reg)
            begin
                // drop the id from every slot holding it
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (valid_reg[s] && (slot_id_reg[s] == b_id_reg))
                    begin
                        valid_next[s] = 1'b0;
                    end
                end
            end
            else
            begin
                // empty slot takes the first offer, else strict improvement only
                center_take = !valid_reg[SLOT_CENTER] || (b_cheb_reg < cheb_reg);
                quad_take   = !valid_reg[b_slot] || (b_prod_reg > prod_reg[b_quad_reg]);
                if (center_take)
                begin
                    valid_next[SLOT_CENTER]   = 1'b1;
                    slot_id_next[SLOT_CENTER] = b_id_reg;
                    slot_x_next[SLOT_CENTER]  = b_x_reg;
                    slot_y_next[SLOT_CENTER]  = b_y_reg;
                end
                if (quad_take)
                begin
                    valid_next[b_slot]   = 1'b1;
                    slot_id_next[b_slot] = b_id_reg;
                    slot_x_next[b_slot]  = b_x_reg;
                    slot_y_next[b_slot]  = b_y_reg;
                end
            end
        end
    end

    // a take loads the new metric; otherwise the held point is re-measured,
    // which follows any change of image size
    assign cheb_next = center_take ? b_cheb_reg
                                   : cheb_of(slot_x_reg[SLOT_CENTER],
                                             slot_y_reg[SLOT_CENTER], cu, cv);

    for (genvar q = 0; q < NUM_QUADS; q++)
    begin : g_quad_metric
        assign prod_next[q] = (quad_take && (b_quad_reg == quad_idx_t'(q)))
                              ? b_prod_reg
                              : prod_of(slot_x_reg[q + 1], slot_y_reg[q + 1], cu, cv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_id_reg <= slot_id_next;
        slot_x_reg  <= slot_x_next;
        slot_y_reg  <= slot_y_next;
        cheb_reg    <= cheb_next;
        prod_reg    <= prod_next;
    end

    // ------------------------------------------------------------------
    // result register, holds while the sink stalls
    // ------------------------------------------------------------------
    logic [ID_OUT_BITS-1:0] out_id_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   out_mask_reg;

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                // empty slots report id zero
                out_id_reg[s] <= valid_next[s] ? ID_OUT_BITS'(slot_id_next[s])
                                               : '0;
            end
            out_mask_reg <= valid_next;
        end
    end

    always_comb
    begin
        m_axis_tdata = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            m_axis_tdata[s*ID_OUT_BITS +: ID_OUT_BITS] = out_id_reg[s];
        end
        m_axis_tdata[OUT_MASK_LSB +: NUM_SLOTS] = out_mask_reg;
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/kss_checker.sv @@
// port-level checks for the keypoint slot selector, bound to the top level
// depends on kss_pkg and keypoint_slot_selector_assert.svh
`default_nettype none

`include "keypoint_slot_selector_assert.svh"

module kss_checker
    import kss_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    logic                  out_stall;
    logic [NUM_SLOTS-1:0]  mask;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign mask      = m_axis_tdata[OUT_MASK_LSB +: NUM_SLOTS];

    // a stalled result keeps its slots
    `KSS_ASSERT_NEXT(a_result_holds, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // the input side only backs up behind a stalled result
    `KSS_ASSERT_NOW(a_stall_source, clk, rst_n, !s_axis_tready, out_stall)

    // an empty slot reports id zero
    for (genvar s = 0; s < NUM_SLOTS; s++)
    begin : g_slot
        logic id_zero;
        assign id_zero = (m_axis_tdata[s*ID_OUT_BITS +: ID_OUT_BITS] == '0);
        `KSS_ASSERT_NOW(a_empty_id, clk, rst_n, m_axis_tvalid && !mask[s], id_zero)
    end

endmodule

bind keypoint_slot_selector kss_checker u_kss_checker (.*);

`default_nettype wire

@@ dv/keypoint_slot_selector_test.sv @@
// self-checking testbench for keypoint_slot_selector: random and directed feature transfers
// depends on kss_pkg and the keypoint_slot_selector rtl; slot contents predicted in a scoreboard class
`timescale 1ns / 100ps

module keypoint_slot_selector_test;
    import kss_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS  = 160;
    // slack after the last result for the three pipeline stages to settle
    localparam int SETTLE_CYCLES = 6;

    // one slot result as it sits in the low bits of m_axis_tdata, centre id lowest
    typedef struct packed {
        logic [NUM_SLOTS-1:0]   valid_mask;
        logic [ID_OUT_BITS-1:0] lower_left_id;
        logic [ID_OUT_BITS-1:0] upper_left_id;
        logic [ID_OUT_BITS-1:0] upper_right_id;
        logic [ID_OUT_BITS-1:0] lower_right_id;
        logic [ID_OUT_BITS-1:0] center_id;
    } slot_view_t;

    // mirror of the five slots plus the queue of slot views still owed by the block
    class slot_tracker;
        logic [CFG_BITS-1:0]    width_px;
        logic [CFG_BITS-1:0]    height_px;
        bit                     held[NUM_SLOTS];
        logic [ID_OUT_BITS-1:0] held_id[NUM_SLOTS];
        logic [15:0]            held_x[NUM_SLOTS];
        logic [15:0]            held_y[NUM_SLOTS];
        slot_view_t             owed_views[$];
        int unsigned            failures;

        function new();
            width_px  = WIDTH_RESET;
            height_px = HEIGHT_RESET;
            failures  = 0;
            foreach (held[i])
                held[i] = 1'b0;
        endfunction

        function void apply_register(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_BITS-1:0] value);
            if (addr == REG_IMAGE_WIDTH)
                width_px = value;
            else if (addr == REG_IMAGE_HEIGHT)
                height_px = value;
        endfunction

        // centre in 11.4, the halving truncates
        function longint centre_x();
            longint c;
            c = longint'(width_px >> 1);
            return c << FRAC_BITS;
        endfunction

        function longint centre_y();
            longint c;
            c = longint'(height_px >> 1);
            return c << FRAC_BITS;
        endfunction

        // chebyshev distance to the centre
        function longint centre_dist(longint x, longint y, longint cu, longint cv);
            longint dx;
            longint dy;
            dx = x - cu;
            dy = y - cv;
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            return (dx > dy) ? dx : dy;
        endfunction

        function longint quad_product(longint x, longint y, longint cu, longint cv);
            return (x - cu) * (y - cv);
        endfunction

        function void fill(slot_idx_t s, logic [15:0] fid, logic [15:0] x, logic [15:0] y);
            held[s]    = 1'b1;
            held_id[s] = fid;
            held_x[s]  = x;
            held_y[s]  = y;
        endfunction

        // update the slots for one accepted feature transfer and owe its view
        function void note_transfer(logic kind, logic [15:0] fid, logic [15:0] x,
                                    logic [15:0] y, logic pt);
            longint     cu;
            longint     cv;
            bit         right;
            bit         lower;
            quad_idx_t  q;
            slot_idx_t  s;
            slot_view_t v;
            cu = centre_x();
            cv = centre_y();
            if (kind == KIND_REMOVE || pt == 1'b0) begin
                // drop the id from every slot that holds it
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (held[i] && held_id[i] == fid)
                        held[i] = 1'b0;
            end
            else begin
                if (!held[SLOT_CENTER] ||
                    centre_dist(longint'(x), longint'(y), cu, cv) <
                    centre_dist(longint'(held_x[SLOT_CENTER]),
                                longint'(held_y[SLOT_CENTER]), cu, cv))
                    fill(SLOT_CENTER, fid, x, y);
                right = (longint'(x) >= cu);
                lower = (longint'(y) >= cv);
                if (right)
                    q = lower ? QUAD_LOWER_RIGHT : QUAD_UPPER_RIGHT;
                else
                    q = lower ? QUAD_LOWER_LEFT : QUAD_UPPER_LEFT;
                s = SLOT_LOWER_RIGHT + q;
                // strict improvement only, an empty slot takes anything
                if (!held[s] ||
                    quad_product(longint'(x), longint'(y), cu, cv) >
                    quad_product(longint'(held_x[s]), longint'(held_y[s]), cu, cv))
                    fill(s, fid, x, y);
            end
            v.center_id      = held[SLOT_CENTER] ? held_id[SLOT_CENTER] : '0;
            v.lower_right_id = held[SLOT_LOWER_RIGHT + QUAD_LOWER_RIGHT] ?
                               held_id[SLOT_LOWER_RIGHT + QUAD_LOWER_RIGHT] : '0;
            v.upper_right_id = held[SLOT_LOWER_RIGHT + QUAD_UPPER_RIGHT] ?
                               held_id[SLOT_LOWER_RIGHT + QUAD_UPPER_RIGHT] : '0;
            v.upper_left_id  = held[SLOT_LOWER_RIGHT + QUAD_UPPER_LEFT] ?
                               held_id[SLOT_LOWER_RIGHT + QUAD_UPPER_LEFT] : '0;
            v.lower_left_id  = held[SLOT_LOWER_RIGHT + QUAD_LOWER_LEFT] ?
                               held_id[SLOT_LOWER_RIGHT + QUAD_LOWER_LEFT] : '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                v.valid_mask[i] = held[i];
            owed_views.insert(owed_views.size(), v);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        // compare one result transfer against the oldest owed view
        function void check_result(logic [OUT_TDATA_BITS-1:0] tdata);
            slot_view_t got;
            slot_view_t want;
            got = tdata[$bits(slot_view_t)-1:0];
            if (owed_views.size() == 0) begin
                $error("slot result %0h with no feature transfer outstanding", got);
                failures++;
                return;
            end
            want = owed_views.pop_front();
            compare_field("center_id", want.center_id, got.center_id);
            compare_field("lower_right_id", want.lower_right_id, got.lower_right_id);
            compare_field("upper_right_id", want.upper_right_id, got.upper_right_id);
            compare_field("upper_left_id", want.upper_left_id, got.upper_left_id);
            compare_field("lower_left_id", want.lower_left_id, got.lower_left_id);
            compare_field("valid_mask", 16'(want.valid_mask), 16'(got.valid_mask));
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr;
    logic [CFG_BITS-1:0]       cfg_wdata;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // tdata: feature_id, feature_x, feature_y, has_point, zero pad
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
    // tuser: kind
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // tdata: center_id, lower_right_id, upper_right_id, upper_left_id,
    //        lower_left_id, valid_mask, zero pad
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    // gaps and stalls only while this is set
    bit          idle_on = 1'b0;
    int unsigned cycle_count = 0;
    slot_tracker tracker = new();

    keypoint_slot_selector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog on a hung handshake or a missing result
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL keypoint_slot_selector");
            $finish;
        end
    end

    // every accepted result transfer is checked at the edge that takes it
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);
    end

    // result side: ready with random stall bursts, changed on the falling edge
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // present one feature transfer, hold it until taken, then note it
    task automatic send_feature(logic kind, logic [15:0] fid, logic [15:0] x,
                                logic [15:0] y, logic pt);
        logic [IN_TDATA_BITS-1:0] word;
        word = '0;
        word[IN_ID_LSB +: ID_IN_BITS]   = fid;
        word[IN_X_LSB +: COORD_IN_BITS] = x;
        word[IN_Y_LSB +: COORD_IN_BITS] = y;
        word[IN_PT_BIT]                 = pt;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            // sender gap lands on whatever the pipeline is doing
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tdata  <= word;
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_transfer(kind, fid, x, y, pt);
    endtask

    // wait for every owed result, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.owed_views.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic write_register(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        tracker.apply_register(addr, value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // coordinate around a centre: exact centre, one lsb off, a repeat for ties,
    // a spread of random width, or anything at all
    function automatic logic [15:0] pick_coord(longint centre, logic [15:0] prev);
        int     mode;
        int     span;
        longint v;
        mode = $urandom_range(0, 9);
        case (mode)
            0: v = longint'($urandom_range(0, 65535));
            1: v = centre;
            2: v = $urandom_range(0, 1) ? centre + 1 : centre - 1;
            3: v = longint'(prev);
            default: begin
                span = 16 << $urandom_range(0, 7);
                v = centre + longint'($urandom_range(0, 2 * span)) - span;
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    initial
    begin : stimulus
        logic [15:0] fid;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] prev_x;
        logic [15:0] prev_y;
        logic        kind;
        logic        pt;
        int          pick;
        logic [CFG_BITS-1:0] w;
        logic [CFG_BITS-1:0] h;
        longint      cu;
        longint      cv;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_IMAGE_WIDTH;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_OFFER;
        m_axis_tready = 1'b0;
        prev_x        = '0;
        prev_y        = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset image size, centre at 5120, 3840
        idle_on = 1'b1;
        cu = tracker.centre_x();
        cv = tracker.centre_y();
        // exactly on the centre: centre slot and lower right both empty
        send_feature(KIND_OFFER, 16'd1, 16'(cu), 16'(cv), 1'b1);
        send_feature(KIND_OFFER, 16'd2, 16'(cu + 16), 16'(cv + 16), 1'b1);
        // one lsb up and left of centre falls in the upper left
        send_feature(KIND_OFFER, 16'd3, 16'(cu - 1), 16'(cv - 1), 1'b1);
        send_feature(KIND_OFFER, 16'd4, 16'(cu + 100), 16'(cv - 50), 1'b1);
        send_feature(KIND_OFFER, 16'd5, 16'(cu - 50), 16'(cv + 100), 1'b1);
        // far corners
        send_feature(KIND_OFFER, 16'd6, 16'h0000, 16'h0000, 1'b1);
        send_feature(KIND_OFFER, 16'd7, 16'hffff, 16'hffff, 1'b1);
        // more negative product in the upper right, no replacement
        send_feature(KIND_OFFER, 16'd8, 16'hffff, 16'h0000, 1'b1);
        // equal product does not replace
        send_feature(KIND_OFFER, 16'd9, 16'hffff, 16'hffff, 1'b1);
        // re-offer of a held id at a worse spot keeps the stored coordinates
        send_feature(KIND_OFFER, 16'd7, 16'(cu + 16), 16'(cv + 16), 1'b1);
        send_feature(KIND_OFFER, 16'd7, 16'h1234, 16'h5678, 1'b0);
        send_feature(KIND_REMOVE, 16'd1, 16'h0000, 16'h0000, 1'b0);
        // removal of an id nobody holds, all field bits high
        send_feature(KIND_REMOVE, 16'hffff, 16'hffff, 16'hffff, 1'b1);
        // one id landing in two slots, then removed from both
        send_feature(KIND_OFFER, 16'hffff, 16'(cu + 3), 16'(cv + 2), 1'b1);
        send_feature(KIND_REMOVE, 16'hffff, 16'(cu), 16'(cv), 1'b1);
        send_feature(KIND_OFFER, 16'h0000, 16'(cu), 16'(cv - 16), 1'b1);
        send_feature(KIND_OFFER, 16'h0000, 16'(cu), 16'(cv - 16), 1'b0);
        // centre improvement needs a strictly smaller distance
        send_feature(KIND_OFFER, 16'd10, 16'(cu + 20), 16'(cv), 1'b1);
        send_feature(KIND_OFFER, 16'd11, 16'(cu - 20), 16'(cv + 20), 1'b1);
        send_feature(KIND_OFFER, 16'd12, 16'(cu - 5), 16'(cv + 5), 1'b1);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // extreme image sizes first, zero included, then random ones
            case (phase)
                0: begin w = 12'd4095; h = 12'd4095; end
                1: begin w = 12'd0;    h = 12'd0;    end
                2: begin w = 12'd1;    h = 12'd1;    end
                3: begin w = 12'd4095; h = 12'd1;    end
                4: begin w = 12'd1;    h = 12'd4095; end
                default: begin
                    w = 12'($urandom_range(0, 4095));
                    h = 12'($urandom_range(0, 4095));
                end
            endcase
            write_register(REG_IMAGE_WIDTH, w);
            write_register(REG_IMAGE_HEIGHT, h);
            // some phases run flat out, the last one always
            idle_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 4) != 0);
            cu = tracker.centre_x();
            cv = tracker.centre_y();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                // a small id pool so that removals and drops hit held slots
                fid = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 15));
                x = pick_coord(cu, prev_x);
                y = pick_coord(cv, prev_y);
                if (pick < 70) begin
                    kind = KIND_OFFER;
                    pt   = 1'b1;
                end
                else if (pick < 82) begin
                    kind = KIND_OFFER;
                    pt   = 1'b0;
                end
                else begin
                    kind = KIND_REMOVE;
                    pt   = 1'($urandom_range(0, 1));
                end
                send_feature(kind, fid, x, y, pt);
                prev_x = x;
                prev_y = y;
            end
            drain();
        end

        if (tracker.failures == 0)
            $display("PASS keypoint_slot_selector");
        else
            $display("FAIL keypoint_slot_selector");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/kss_pkg.sv
hw/rtl/keypoint_slot_selector.sv
hw/rtl/kss_checker.sv
dv/keypoint_slot_selector_test.sv
